// File: sv/sfc_pkg.sv
package sfc_pkg;

    // Filler byte stored on a strobe rise
    localparam logic [7:0] FILLER_BYTE = 8'hFF;

    // One input request
    typedef struct packed {
        logic func;
        logic strobe_fall;
        logic strobe_rise;
        logic clock_rise;
        logic data_bit;
    } t_in;

    // One result
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_ready;
        logic       last_byte;
    } t_out;

    // Read command passed from front to back
    typedef enum logic {
        CMD_NOTREADY,
        CMD_FRAME
    } t_cmd;

    // Front status
    typedef struct packed {
        logic held;
        logic busy;
    } t_front_stat;

    // Back status
    typedef struct packed {
        logic idle;
    } t_back_stat;

endpackage

// File: sv/sfc_ram.sv
module sfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/sfc_front.sv
module sfc_front #(
    parameter int FRAME_BYTES = 16,
    parameter int IDX_W       = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sfc_pkg::t_in         i_item,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic                 i_cmdq_full,
    output logic                 o_cmdq_push,
    output sfc_pkg::t_cmd        o_cmdq_cmd,
    input  logic                 i_frame_done,
    output logic                 o_we,
    output logic [IDX_W-1:0]     o_waddr,
    output logic [7:0]           o_wdata,
    output sfc_pkg::t_front_stat o_stat
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    logic [IDX_W-1:0] r_wi, n_wi;
    logic             r_held, n_held;
    logic             r_active, n_active;
    logic [2:0]       r_bc, n_bc;
    logic [7:0]       r_shift, n_shift;
    logic             r_busy, n_busy;

    logic       accept;
    logic       do_store;
    logic [7:0] store_val;
    logic [7:0] shifted;

    // Stall while a held frame is being read out of the store, or while the command queue is full
    assign o_full = r_busy || i_cmdq_full;
    assign accept = i_push && !o_full;
    assign shifted = r_shift | (8'(i_item.data_bit) << r_bc);

    // Classify request and update receiver state
    always_comb begin
        n_wi        = r_wi;
        n_held      = r_held;
        n_active    = r_active;
        n_bc        = r_bc;
        n_shift     = r_shift;
        n_busy      = r_busy && !i_frame_done;
        do_store    = 1'b0;
        store_val   = sfc_pkg::FILLER_BYTE;
        o_cmdq_push = 1'b0;
        o_cmdq_cmd  = sfc_pkg::CMD_NOTREADY;

        if (accept) begin
            if (i_item.func) begin
                o_cmdq_push = 1'b1;
                if (r_held) begin
                    o_cmdq_cmd = sfc_pkg::CMD_FRAME;
                    n_held     = 1'b0;
                    n_busy     = 1'b1;
                end
            end else if (i_item.strobe_fall || i_item.strobe_rise || i_item.clock_rise) begin
                if (r_held) begin
                    n_active = 1'b0;
                    n_bc     = 3'd0;
                    n_shift  = 8'd0;
                end else if (i_item.strobe_fall) begin
                    n_active = 1'b1;
                    n_bc     = 3'd0;
                    n_shift  = 8'd0;
                    n_wi     = '0;
                end else if (i_item.strobe_rise) begin
                    do_store = 1'b1;
                end else if (r_active) begin
                    // clock rise: shift in LSB first
                    if (r_bc == 3'd7) begin
                        do_store  = 1'b1;
                        store_val = shifted;
                        n_bc      = 3'd0;
                        n_shift   = 8'd0;
                    end else begin
                        n_bc    = r_bc + 3'd1;
                        n_shift = shifted;
                    end
                end
            end
        end

        // Store byte; buffer full holds the frame
        if (do_store) begin
            if (r_wi == LAST_IDX) begin
                n_held   = 1'b1;
                n_wi     = '0;
                n_active = 1'b0;
                n_bc     = 3'd0;
                n_shift  = 8'd0;
            end else begin
                n_wi = r_wi + 1'b1;
            end
        end
    end

    assign o_we    = do_store;
    assign o_waddr = r_wi;
    assign o_wdata = store_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi     <= '0;
            r_held   <= 1'b0;
            r_active <= 1'b0;
            r_bc     <= 3'd0;
            r_shift  <= 8'd0;
            r_busy   <= 1'b0;
        end else begin
            r_wi     <= n_wi;
            r_held   <= n_held;
            r_active <= n_active;
            r_bc     <= n_bc;
            r_shift  <= n_shift;
            r_busy   <= n_busy;
        end
    end

    assign o_stat.held = r_held;
    assign o_stat.busy = r_busy;

endmodule

// File: sv/sfc_cmdq.sv
module sfc_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sfc_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output sfc_pkg::t_cmd o_cmd,
    output logic          o_empty
);

    sfc_pkg::t_cmd r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          push_fire, pop_fire;

    assign o_full    = (r_cnt == 2'd2);
    assign o_empty   = (r_cnt == 2'd0);
    assign push_fire = i_push && !o_full;
    assign pop_fire  = i_pop && !o_empty;
    assign o_cmd     = r_q[r_rp];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_fire) begin
                r_wp <= ~r_wp;
            end
            if (pop_fire) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push_fire) - 2'(pop_fire);
        end
    end

    // Entries
    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_q[r_wp] <= i_cmd;
        end
    end

endmodule

// File: sv/sfc_back.sv
module sfc_back #(
    parameter int FRAME_BYTES = 16,
    parameter int IDX_W       = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmdq_empty,
    input  sfc_pkg::t_cmd       i_cmdq_cmd,
    output logic                o_cmdq_pop,
    output logic [IDX_W-1:0]    o_raddr,
    input  logic [7:0]          i_rdata,
    output logic                o_frame_done,
    output sfc_pkg::t_out       o_result,
    output logic                o_empty,
    input  logic                i_pop,
    output sfc_pkg::t_back_stat o_stat
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_k;
    logic             r_pend;
    logic             r_pend_last;
    sfc_pkg::t_out    r_q [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    logic          pop_fire;
    logic [1:0]    cnt_after;
    logic          room;
    logic          issue;
    logic          nr_push;
    logic          res_push;
    sfc_pkg::t_out res_data;

    // Result queue room, counting a read still in flight
    assign pop_fire  = i_pop && (r_cnt != 2'd0);
    assign cnt_after = r_cnt - 2'(pop_fire);
    assign room      = (cnt_after + 2'(r_pend)) < 2'd2;

    assign issue        = (r_state == ST_STREAM) && room;
    assign o_frame_done = issue && (r_k == LAST_IDX);
    assign o_raddr      = r_k;

    // Not-ready answer needs no store access
    assign nr_push = (r_state == ST_IDLE) && !i_cmdq_empty
                     && (i_cmdq_cmd == sfc_pkg::CMD_NOTREADY) && !r_pend && room;
    assign o_cmdq_pop = (r_state == ST_IDLE) && !i_cmdq_empty
                        && ((i_cmdq_cmd == sfc_pkg::CMD_FRAME) || nr_push);

    // Result to enqueue: store data returning, or a not-ready answer
    always_comb begin
        res_push = r_pend || nr_push;
        if (r_pend) begin
            res_data.frame_byte  = i_rdata;
            res_data.frame_ready = 1'b1;
            res_data.last_byte   = r_pend_last;
        end else begin
            res_data.frame_byte  = 8'd0;
            res_data.frame_ready = 1'b0;
            res_data.last_byte   = 1'b1;
        end
    end

    // Sequencer and result queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_wp        <= 1'b0;
            r_rp        <= 1'b0;
            r_cnt       <= 2'd0;
        end else begin
            r_pend      <= issue;
            r_pend_last <= o_frame_done;
            case (r_state)
                ST_IDLE: begin
                    if (o_cmdq_pop && (i_cmdq_cmd == sfc_pkg::CMD_FRAME)) begin
                        r_state <= ST_STREAM;
                        r_k     <= '0;
                    end
                end
                ST_STREAM: begin
                    if (issue) begin
                        if (r_k == LAST_IDX) begin
                            r_state <= ST_IDLE;
                            r_k     <= '0;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (res_push) begin
                r_wp <= ~r_wp;
            end
            if (pop_fire) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(res_push) - 2'(pop_fire);
        end
    end

    // Result queue entries
    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_q[r_wp] <= res_data;
        end
    end

    assign o_result    = r_q[r_rp];
    assign o_empty     = (r_cnt == 2'd0);
    assign o_stat.idle = (r_state == ST_IDLE) && !r_pend;

endmodule

// File: sv/strobed_serial_frame_capture.sv
// Strobed serial frame capture: watches a strobe/clock/data bus and captures a frame of
// FRAME_BYTES bytes, assembled LSB first, with a 0xFF filler stored on each strobe rise.
// Bus event requests and read requests are taken one per cycle while full is low. A read
// of a held frame streams FRAME_BYTES results, one per cycle while the result queue has room,
// through the single read port of the frame store, and input stays full from that read
// until the last store read has been issued: the read is first handed to the back end,
// then one store read is made per byte, and the stall lasts longer when the consumer stalls.
// A read with no frame held gives one not-ready result and does not set the busy stall.
// The frame store is not cleared after reset or after a read: a frame is only
// held once every entry has been written since the last rewind.
module strobed_serial_frame_capture #(
    parameter int FRAME_BYTES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sfc_pkg::t_in  i_item,
    input  logic          push,
    output logic          full,
    output sfc_pkg::t_out o_result,
    output logic          empty,
    input  logic          pop
);

    localparam int IDX_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

    logic                 cmdq_push, cmdq_full, cmdq_pop, cmdq_empty;
    sfc_pkg::t_cmd        cmdq_in, cmdq_out;
    logic                 frame_done;
    logic                 we;
    logic [IDX_W-1:0]     waddr, raddr;
    logic [7:0]           wdata, rdata;
    sfc_pkg::t_front_stat front_stat;
    sfc_pkg::t_back_stat  back_stat;

    sfc_front #(
        .FRAME_BYTES(FRAME_BYTES),
        .IDX_W      (IDX_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_push      (push),
        .o_full      (full),
        .i_cmdq_full (cmdq_full),
        .o_cmdq_push (cmdq_push),
        .o_cmdq_cmd  (cmdq_in),
        .i_frame_done(frame_done),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_stat      (front_stat)
    );

    sfc_cmdq u_cmdq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (cmdq_push),
        .i_cmd  (cmdq_in),
        .o_full (cmdq_full),
        .i_pop  (cmdq_pop),
        .o_cmd  (cmdq_out),
        .o_empty(cmdq_empty)
    );

    sfc_ram #(
        .WIDTH(8),
        .DEPTH(FRAME_BYTES),
        .AW   (IDX_W)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    sfc_back #(
        .FRAME_BYTES(FRAME_BYTES),
        .IDX_W      (IDX_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmdq_empty(cmdq_empty),
        .i_cmdq_cmd  (cmdq_out),
        .o_cmdq_pop  (cmdq_pop),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_frame_done(frame_done),
        .o_result    (o_result),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_stat      (back_stat)
    );

`ifndef ASSERT_OFF
    // Reading a held frame blocks input until the store has been read out
    a_held_read_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && i_item.func && front_stat.held) |=> full)
        else $error("input not stalled after read of held frame");

    // A held frame is released only by a read request
    a_release_by_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(front_stat.held) |-> $past(push && !full && i_item.func))
        else $error("held frame released without a read");

    // With nothing pending and no read taken, no result appears
    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmdq_empty && back_stat.idle && empty && !(push && !full && i_item.func))
        |=> empty)
        else $error("result appeared without a read");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int FRAME_LEN  = 16;
    localparam int WDOG_LIMIT = 4000;
    localparam int TAIL_WAIT  = 20;
    localparam int PHASE_REQS = 20;

    // Request codes, bit order {func, strobe_fall, strobe_rise, clock_rise, data_bit}
    localparam sfc_pkg::t_in REQ_EMPTY   = 5'b0_0000;
    localparam sfc_pkg::t_in REQ_DATA    = 5'b0_0001;
    localparam sfc_pkg::t_in REQ_CLK0    = 5'b0_0010;
    localparam sfc_pkg::t_in REQ_CLK1    = 5'b0_0011;
    localparam sfc_pkg::t_in REQ_RISE    = 5'b0_0100;
    localparam sfc_pkg::t_in REQ_RISECK  = 5'b0_0111;
    localparam sfc_pkg::t_in REQ_FALL    = 5'b0_1000;
    localparam sfc_pkg::t_in REQ_FALLCK  = 5'b0_1011;
    localparam sfc_pkg::t_in REQ_FALLRS  = 5'b0_1100;
    localparam sfc_pkg::t_in REQ_READ    = 5'b1_0000;
    localparam sfc_pkg::t_in REQ_READFL  = 5'b1_1000;
    localparam sfc_pkg::t_in REQ_READALL = 5'b1_1111;

    // Read with no frame held: byte 0, not ready, last
    localparam sfc_pkg::t_out NOT_READY_RES = 10'b0000_0000_0_1;

    // Directed stimulus row
    typedef struct packed {
        sfc_pkg::t_in  req;
        logic [7:0]    reps;
        logic          typed;
        sfc_pkg::t_out want;
    } t_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    sfc_pkg::t_in  i_item;
    logic          push;
    logic          full;
    sfc_pkg::t_out o_result;
    logic          empty;
    logic          pop;

    strobed_serial_frame_capture #(
        .FRAME_BYTES(FRAME_LEN)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .push    (push),
        .full    (full),
        .o_result(o_result),
        .empty   (empty),
        .pop     (pop)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow of the capture state
    logic [7:0]  shadow_frame [FRAME_LEN];
    int unsigned wr_at;
    bit          held;
    bit          rx_on;
    int unsigned nbits;
    logic [7:0]  shacc;

    sfc_pkg::t_out bytes_due [$];
    t_row          dir_rows [$];

    int            idle_pct;
    int            stall_pct;
    int            mismatches;
    int            reqs_taken;
    int            quiet_cycles;
    sfc_pkg::t_out head_res;

    function automatic void rx_idle();
        rx_on = 1'b0;
        nbits = 0;
        shacc = 8'h00;
    endfunction

    // Store one byte; a full buffer is held and the receiver drops out
    function automatic void keep_byte(input logic [7:0] v);
        if (held)
            return;
        if (wr_at < FRAME_LEN)
            shadow_frame[wr_at] = v;
        wr_at++;
        if (wr_at >= FRAME_LEN) begin
            held  = 1'b1;
            wr_at = 0;
            rx_idle();
        end
    endfunction

    // Advance the shadow state by one request and queue its results
    function automatic void advance_capture(input sfc_pkg::t_in r);
        sfc_pkg::t_out o;
        logic [7:0]    done;
        if (r.func) begin
            if (!held) begin
                bytes_due.push_back(NOT_READY_RES);
                return;
            end
            for (int k = 0; k < FRAME_LEN; k++) begin
                o.frame_byte  = shadow_frame[k];
                o.frame_ready = 1'b1;
                o.last_byte   = (k == FRAME_LEN - 1);
                bytes_due.push_back(o);
            end
            for (int k = 0; k < FRAME_LEN; k++)
                shadow_frame[k] = 8'h00;
            held = 1'b0;
            return;
        end
        if (!r.strobe_fall && !r.strobe_rise && !r.clock_rise)
            return;
        // priority: held, fall, rise, idle receiver, clock
        if (held) begin
            rx_idle();
        end else if (r.strobe_fall) begin
            rx_on = 1'b1;
            nbits = 0;
            shacc = 8'h00;
            wr_at = 0;
        end else if (r.strobe_rise) begin
            keep_byte(sfc_pkg::FILLER_BYTE);
        end else if (rx_on) begin
            shacc = shacc | (8'(r.data_bit) << nbits);
            nbits++;
            if (nbits >= 8) begin
                done  = shacc;
                nbits = 0;
                shacc = 8'h00;
                keep_byte(done);
            end
        end
    endfunction

    // Present one request, hold it until taken, then predict
    task automatic send_req(input sfc_pkg::t_in r);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            push   <= 1'b0;
            i_item <= sfc_pkg::t_in'($urandom_range(0, 31));
            @(negedge i_clk);
        end
        i_item <= r;
        push   <= 1'b1;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        advance_capture(r);
        reqs_taken++;
    endtask

    // Hold off input until every queued result has been popped
    task automatic drain_wait();
        @(negedge i_clk);
        push <= 1'b0;
        while (bytes_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic add_row(input sfc_pkg::t_in r, input int n, input bit typed,
                           input sfc_pkg::t_out want);
        t_row row;
        row.req   = r;
        row.reps  = n[7:0];
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // Frame start, up to 16 bytes of clocked bits or fillers, read if all sent
    task automatic send_frame();
        bit cut;
        int nbytes;
        cut    = ($urandom_range(0, 5) == 0);
        nbytes = cut ? $urandom_range(1, FRAME_LEN - 1) : FRAME_LEN;
        send_req(REQ_FALL | sfc_pkg::t_in'($urandom_range(0, 3)));
        for (int b = 0; b < nbytes; b++) begin
            if ($urandom_range(0, 3) == 0) begin
                for (int k = 0; k < 8; k++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_req(REQ_EMPTY | sfc_pkg::t_in'($urandom_range(0, 1)));
                    send_req(REQ_CLK0 | sfc_pkg::t_in'($urandom_range(0, 1)));
                end
            end else begin
                send_req(REQ_RISE | sfc_pkg::t_in'($urandom_range(0, 3)));
            end
        end
        if (!cut) begin
            repeat ($urandom_range(0, 2))
                send_req(sfc_pkg::t_in'({$urandom_range(1, 7), 1'($urandom_range(0, 1))}));
            send_req(REQ_READ | sfc_pkg::t_in'($urandom_range(0, 15)));
        end
    endtask

    // Result check against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (bytes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t unexpected result byte=%02h ready=%b last=%b", $realtime,
                             o_result.frame_byte, o_result.frame_ready, o_result.last_byte);
            end else begin
                head_res = bytes_due.pop_front();
                if (o_result.frame_byte !== head_res.frame_byte ||
                    o_result.frame_ready !== head_res.frame_ready ||
                    o_result.last_byte !== head_res.last_byte) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t mismatch exp %02h/%b/%b got %02h/%b/%b",
                                 $realtime, head_res.frame_byte, head_res.frame_ready,
                                 head_res.last_byte, o_result.frame_byte,
                                 o_result.frame_ready, o_result.last_byte);
                end
            end
        end
    end

    // Receiver stalls
    always @(negedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int phase_start;
        int pick;
        i_rst_n      = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        i_item       = REQ_EMPTY;
        idle_pct     = 0;
        stall_pct    = 0;
        mismatches   = 0;
        reqs_taken   = 0;
        quiet_cycles = 0;
        for (int k = 0; k < FRAME_LEN; k++)
            shadow_frame[k] = 8'h00;
        wr_at = 0;
        held  = 1'b0;
        rx_idle();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows
        add_row(REQ_READ,    1,  1'b1, NOT_READY_RES);  // nothing held after reset
        add_row(REQ_DATA,    1,  1'b0, '0);             // no edge, data high
        add_row(REQ_CLK1,    1,  1'b0, '0);             // clock with receiver idle
        add_row(REQ_RISE,    1,  1'b0, '0);             // filler with receiver idle
        add_row(REQ_FALLCK,  1,  1'b0, '0);             // fall beats clock
        add_row(REQ_CLK1,    1,  1'b0, '0);
        add_row(REQ_CLK0,    7,  1'b0, '0);             // 0x01
        add_row(REQ_CLK0,    7,  1'b0, '0);
        add_row(REQ_CLK1,    1,  1'b0, '0);             // 0x80
        add_row(REQ_CLK1,    8,  1'b0, '0);             // 0xFF
        add_row(REQ_CLK0,    3,  1'b0, '0);             // partial byte
        add_row(REQ_RISECK,  1,  1'b0, '0);             // rise beats clock, bits kept
        add_row(REQ_CLK0,    5,  1'b0, '0);             // finishes the partial byte
        add_row(REQ_FALLRS,  1,  1'b0, '0);             // fall beats rise, rewind
        add_row(REQ_RISE,    15, 1'b0, '0);
        add_row(REQ_CLK1,    3,  1'b0, '0);
        add_row(REQ_CLK0,    5,  1'b0, '0);             // last byte fills the buffer
        add_row(REQ_CLK1,    1,  1'b0, '0);             // events while held
        add_row(REQ_FALL,    1,  1'b0, '0);
        add_row(REQ_RISE,    1,  1'b0, '0);
        add_row(REQ_EMPTY,   1,  1'b0, '0);
        add_row(REQ_READ,    1,  1'b0, '0);             // full frame out
        add_row(REQ_READ,    1,  1'b1, NOT_READY_RES);  // store released
        add_row(REQ_FALL,    1,  1'b0, '0);
        add_row(REQ_RISE,    16, 1'b0, '0);             // frame of fillers
        add_row(REQ_READALL, 1,  1'b0, '0);
        add_row(REQ_READFL,  1,  1'b1, NOT_READY_RES);

        foreach (dir_rows[i]) begin
            repeat (dir_rows[i].reps) begin
                send_req(dir_rows[i].req);
                if (dir_rows[i].typed) begin
                    void'(bytes_due.pop_back());
                    bytes_due.push_back(dir_rows[i].want);
                end
            end
        end

        // Random phases: no idling, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            drain_wait();
            idle_pct    = (ph == 1) ? 57 : (ph == 3) ? 28 : 0;
            stall_pct   = (ph == 2) ? 57 : (ph == 3) ? 28 : 0;
            phase_start = reqs_taken;
            while (reqs_taken - phase_start < PHASE_REQS) begin
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    send_frame();
                end else if (pick < 9) begin
                    repeat ($urandom_range(3, 12)) begin
                        if ($urandom_range(0, 7) == 0)
                            send_req(REQ_READ | sfc_pkg::t_in'($urandom_range(0, 15)));
                        else
                            send_req(sfc_pkg::t_in'($urandom_range(0, 15)));
                    end
                end else begin
                    send_req(REQ_READ | sfc_pkg::t_in'($urandom_range(0, 15)));
                end
            end
        end

        drain_wait();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
sv/sfc_pkg.sv
sv/sfc_ram.sv
sv/sfc_front.sv
sv/sfc_cmdq.sv
sv/sfc_back.sv
sv/strobed_serial_frame_capture.sv
dv/testbench.sv
